### src/mlcd_pkg.sv
package mlcd_pkg;

    // Panel geometry and derived store sizes.
    localparam int WIDTH       = 400;
    localparam int HEIGHT      = 240;
    localparam int ROW_BYTES   = WIDTH / 8;
    localparam int STORE_BYTES = HEIGHT * ROW_BYTES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int IDX_W       = $clog2(ROW_BYTES + 1);

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input command codes.
    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Operations passed from the front part to the back part.
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_TRAIL = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Bytes of the panel protocol.
    localparam logic [7:0] MODE_UPDATE = 8'h01;
    localparam logic [7:0] MODE_CLEAR  = 8'h04;
    localparam logic [7:0] TRAILER     = 8'h00;
    localparam logic [7:0] WHITE_BYTE  = 8'hFF;

    // One classified item waiting for the back part.
    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              white;
        logic [9:0]        line;
        logic              eob;
    } t_op;

endpackage

### src/mlcd_ram.sv
module mlcd_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_addr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Single port with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mlcd_front.sv
module mlcd_front import mlcd_pkg::*; (
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [8:0] i_pixel_x,
    input  logic [9:0] i_pixel_y,
    input  logic       i_white,
    input  logic [9:0] i_line_number,
    input  logic       i_end_of_block,
    input  logic       i_q_full,
    input  logic       i_sweeping,
    output logic       o_push,
    output t_op        o_entry
);

    logic accept;
    logic px_ok;
    logic line_ok;
    logic keep;

    // No item is taken while the queue is full or the store is being whitened.
    assign busy   = i_q_full || i_sweeping;
    assign accept = start && !busy;

    // Range checks on the pixel position and the line number.
    assign px_ok = (32'(i_pixel_x) < WIDTH) && (32'(i_pixel_x >> 3) < ROW_BYTES)
                   && (32'(i_pixel_y) < HEIGHT);
    assign line_ok = (i_line_number != 10'd0) && (32'(i_line_number) <= HEIGHT);

    // Classify the item; items that cause nothing are dropped here.
    always_comb begin
        o_entry.op      = OP_PIXEL;
        o_entry.addr    = '0;
        o_entry.bit_sel = i_pixel_x[2:0];
        o_entry.white   = i_white;
        o_entry.line    = i_line_number;
        o_entry.eob     = i_end_of_block;
        keep            = 1'b0;
        unique case (i_command)
            CMD_PIXEL: begin
                o_entry.op   = OP_PIXEL;
                o_entry.addr = ADDR_W'(ADDR_W'(i_pixel_y) * ADDR_W'(ROW_BYTES))
                               + ADDR_W'(i_pixel_x >> 3);
                keep         = px_ok;
            end
            CMD_LINE: begin
                if (line_ok) begin
                    o_entry.op   = OP_LINE;
                    o_entry.addr = ADDR_W'(ADDR_W'(i_line_number - 10'd1)
                                   * ADDR_W'(ROW_BYTES));
                    keep         = 1'b1;
                end else begin
                    o_entry.op = OP_TRAIL;
                    keep       = i_end_of_block;
                end
            end
            CMD_CLEAR: begin
                o_entry.op = OP_CLEAR;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = accept && keep;

endmodule

### src/mlcd_queue.sv
module mlcd_queue import mlcd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_entry,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_op  o_head
);

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;

    assign o_full  = (32'(r_count) == Q_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (32'(r_wr_ptr) == Q_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (32'(r_rd_ptr) == Q_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/mlcd_back.sv
module mlcd_back import mlcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wide_mode,
    input  logic       i_q_empty,
    input  t_op        i_head,
    output logic       o_pop,
    output logic       o_sweeping,
    output logic       o_strobe,
    output logic [7:0] o_spi_byte,
    output logic       o_frame_start,
    output logic       o_frame_end,
    output logic       o_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PXRD  = 4'd1;
    localparam logic [3:0] S_PXWR  = 4'd2;
    localparam logic [3:0] S_HDR0  = 4'd3;
    localparam logic [3:0] S_HDR1  = 4'd4;
    localparam logic [3:0] S_DATA  = 4'd5;
    localparam logic [3:0] S_TR0   = 4'd6;
    localparam logic [3:0] S_TR1   = 4'd7;
    localparam logic [3:0] S_CLR0  = 4'd8;
    localparam logic [3:0] S_CLR1  = 4'd9;
    localparam logic [3:0] S_SWEEP = 4'd10;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    t_op               r_op;
    t_op               n_op;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_xfer_open;
    logic              n_xfer_open;
    logic              r_after_clr;
    logic              n_after_clr;
    logic [ADDR_W-1:0] r_sweep_addr;
    logic [ADDR_W-1:0] n_sweep_addr;
    logic              r_strobe;
    logic              n_strobe;
    logic [7:0]        r_byte;
    logic [7:0]        n_byte;
    logic              r_fs;
    logic              n_fs;
    logic              r_fe;
    logic              n_fe;
    logic              r_last;
    logic              n_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [7:0]        px_mask;

    mlcd_ram #(
        .P_WIDTH (8),
        .P_DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign px_mask    = 8'd1 << r_op.bit_sel;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_sweeping = (r_state == S_SWEEP);

    // Sequencer: fetches a queued item and walks through its bytes and store accesses.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_xfer_open  = r_xfer_open;
        n_after_clr  = r_after_clr;
        n_sweep_addr = r_sweep_addr;
        n_strobe     = 1'b0;
        n_byte       = r_byte;
        n_fs         = 1'b0;
        n_fe         = 1'b0;
        n_last       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = r_op.addr;
        ram_wdata    = WHITE_BYTE;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_op  = i_head;
                    n_idx = '0;
                    unique case (i_head.op)
                        OP_PIXEL: n_state = S_PXRD;
                        OP_LINE:  n_state = S_HDR0;
                        OP_TRAIL: begin
                            n_after_clr = 1'b0;
                            n_state     = r_xfer_open ? S_TR0 : S_IDLE;
                        end
                        default: begin
                            n_after_clr = 1'b1;
                            n_state     = r_xfer_open ? S_TR0 : S_CLR0;
                        end
                    endcase
                end
            end
            S_PXRD: begin
                n_state = S_PXWR;
            end
            S_PXWR: begin
                ram_we    = 1'b1;
                ram_wdata = r_op.white ? (ram_rdata | px_mask) : (ram_rdata & ~px_mask);
                n_state   = S_IDLE;
            end
            S_HDR0: begin
                n_strobe    = 1'b1;
                n_byte      = i_wide_mode ? {r_op.line[1:0], 6'b000001} : MODE_UPDATE;
                n_fs        = !r_xfer_open;
                n_xfer_open = 1'b1;
                n_state     = S_HDR1;
            end
            S_HDR1: begin
                // Fetch of the first row byte overlaps the address byte.
                n_strobe = 1'b1;
                n_byte   = i_wide_mode ? r_op.line[9:2] : r_op.line[7:0];
                ram_addr = r_op.addr + ADDR_W'(r_idx);
                n_idx    = r_idx + 1'b1;
                n_state  = S_DATA;
            end
            S_DATA: begin
                // The read data holds the byte at index r_idx - 1.
                n_strobe = 1'b1;
                n_byte   = ram_rdata;
                if (32'(r_idx) == ROW_BYTES) begin
                    n_last  = !r_op.eob;
                    n_after_clr = 1'b0;
                    n_state = r_op.eob ? S_TR0 : S_IDLE;
                end else begin
                    ram_addr = r_op.addr + ADDR_W'(r_idx);
                    n_idx    = r_idx + 1'b1;
                end
            end
            S_TR0: begin
                n_strobe = 1'b1;
                n_byte   = TRAILER;
                n_state  = S_TR1;
            end
            S_TR1: begin
                n_strobe    = 1'b1;
                n_byte      = TRAILER;
                n_fe        = 1'b1;
                n_last      = !r_after_clr;
                n_xfer_open = 1'b0;
                n_state     = r_after_clr ? S_CLR0 : S_IDLE;
            end
            S_CLR0: begin
                n_strobe = 1'b1;
                n_byte   = MODE_CLEAR;
                n_fs     = 1'b1;
                n_state  = S_CLR1;
            end
            S_CLR1: begin
                n_strobe     = 1'b1;
                n_byte       = TRAILER;
                n_fe         = 1'b1;
                n_last       = 1'b1;
                n_xfer_open  = 1'b0;
                n_sweep_addr = '0;
                n_state      = S_SWEEP;
            end
            S_SWEEP: begin
                // Whiten the store one byte per cycle.
                ram_we       = 1'b1;
                ram_addr     = r_sweep_addr;
                ram_wdata    = WHITE_BYTE;
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (32'(r_sweep_addr) == STORE_BYTES - 1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts with a whitening sweep of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_xfer_open  <= 1'b0;
            r_after_clr  <= 1'b0;
            r_sweep_addr <= '0;
            r_idx        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_xfer_open  <= n_xfer_open;
            r_after_clr  <= n_after_clr;
            r_sweep_addr <= n_sweep_addr;
            r_idx        <= n_idx;
            r_strobe     <= n_strobe;
        end
    end

    // Current item and result payload.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_byte <= n_byte;
        r_fs   <= n_fs;
        r_fe   <= n_fe;
        r_last <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_spi_byte    = r_byte;
    assign o_frame_start = r_fs;
    assign o_frame_end   = r_fe;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    // Row bytes only stream inside an open transfer.
    a_data_in_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> r_xfer_open)
        else $error("row byte outside an open transfer");

    // The closing byte of a transfer leaves no transfer open.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_fe) |-> !r_xfer_open)
        else $error("transfer still open after frame end");

    // A frame start is only given when no transfer was open.
    a_start_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_fs) |-> !$past(r_xfer_open))
        else $error("frame start inside an open transfer");

    // The last result of an item is never directly followed by another result.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |=> !r_strobe)
        else $error("result directly after the last result of an item");
`endif

endmodule

### src/memory_lcd_frame_updater.sv
// Line send: a queued item gives a mode byte, an address byte and ROW_BYTES row bytes at one
// byte per cycle (two trailer bytes follow at end of block), paced by the store read.
// Pixel write: read-modify-write on the single store port (read, then masked write); no result.
// Clear-all: two or four bytes, then whitening of all STORE_BYTES (12000) bytes with busy high.
// Reset: synchronous; afterwards busy stays high for the same whitening pass.
// Results come with a one-cycle strobe; the receiver cannot stall.
module memory_lcd_frame_updater import mlcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [8:0] i_pixel_x,
    input  logic [9:0] i_pixel_y,
    input  logic       i_white,
    input  logic [9:0] i_line_number,
    input  logic       i_end_of_block,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    output logic       o_strobe,
    output logic [7:0] o_spi_byte,
    output logic       o_frame_start,
    output logic       o_frame_end,
    output logic       o_last
);

    logic r_wide_mode;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    logic sweeping;
    t_op  entry;
    t_op  head;

    // Address mode register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wide_mode <= i_cfg_data;
        end
    end

    mlcd_front u_front (
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_white        (i_white),
        .i_line_number  (i_line_number),
        .i_end_of_block (i_end_of_block),
        .i_q_full       (q_full),
        .i_sweeping     (sweeping),
        .o_push         (push),
        .o_entry        (entry)
    );

    mlcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    mlcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wide_mode   (r_wide_mode),
        .i_q_empty     (q_empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_sweeping    (sweeping),
        .o_strobe      (o_strobe),
        .o_spi_byte    (o_spi_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last)
    );

endmodule
